// ===== sv/assert_macros.svh =====
// Assertion macros shared by the generator RTL.
// No dependencies; included by the modules that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge outside reset.
`define CHK_ALWAYS(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// The consequent holds at the edge where the antecedent holds.
`define CHK_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds at the edge after the antecedent.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/mtg_pkg.sv =====
// Shared types, constants and word functions of the MT19937 generator.
// No dependencies; imported by every module of the block.
package mtg_pkg;

  localparam int STATE_WORDS  = 624;
  localparam int WORD_BITS    = 32;
  localparam int TWIST_OFFSET = 397;
  localparam int IDX_BITS     = $clog2(STATE_WORDS);

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [IDX_BITS-1:0]  idx_t;

  localparam word_t TWIST_MATRIX = 32'h9908_b0df;
  localparam word_t TEMPER_B     = 32'h9d2c_5680;
  localparam word_t TEMPER_C     = 32'hefc6_0000;
  localparam word_t SEED_MULT    = 32'd1812433253;
  localparam idx_t  LAST_INDEX   = IDX_BITS'(STATE_WORDS - 1);

  // Control from the reseed sequencer to the cell chain.
  typedef struct packed {
    logic  busy;
    logic  push;
    word_t word;
  } seed_ctl_t;

  // Twist of the current word with its successor and the far word.
  function automatic word_t twist(input word_t cur, input word_t nxt, input word_t far);
    word_t y;
    y = {cur[WORD_BITS-1], nxt[WORD_BITS-2:0]};
    return far ^ (y >> 1) ^ (y[0] ? TWIST_MATRIX : '0);
  endfunction

  // Output tempering.
  function automatic word_t temper(input word_t w);
    word_t z;
    z = w ^ (w >> 11);
    z = z ^ ((z << 7) & TEMPER_B);
    z = z ^ ((z << 15) & TEMPER_C);
    z = z ^ (z >> 18);
    return z;
  endfunction

endpackage

// ===== sv/mtg_cell.sv =====
// One word of the generator state, loaded from its neighbor on a shift.
// Depends on mtg_pkg.
module mtg_cell (
  input  logic          clk,
  input  logic          shift_en,
  input  mtg_pkg::word_t shift_in,
  output mtg_pkg::word_t word
);
  import mtg_pkg::*;

  word_t word_r;

  // Take the neighbor's word whenever the chain advances.
  always_ff @(posedge clk) begin
    if (shift_en) begin
      word_r <= shift_in;
    end
  end

  assign word = word_r;

endmodule

// ===== sv/mtg_seeder.sv =====
// Reseed sequencer: produces the seed words one by one for the chain tail.
// Depends on mtg_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mtg_seeder (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  mtg_pkg::word_t      seed,
  input  mtg_pkg::word_t      tail_word,
  output mtg_pkg::seed_ctl_t  ctl
);
  import mtg_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_LOAD, ST_MUL, ST_ADD} st_t;

  st_t   st_r;
  idx_t  count_r;
  word_t acc_r;
  word_t mix;
  word_t product;

  // Multiply stage of the recurrence on the word last pushed.
  always_comb begin
    mix     = tail_word ^ (tail_word >> 30);
    product = SEED_MULT * mix;
  end

  // Sequencer: load the seed, then one multiply and one add per word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_IDLE;
      count_r <= '0;
    end else begin
      case (st_r)
        ST_IDLE: begin
          if (start) begin
            acc_r <= seed;
            st_r  <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          count_r <= idx_t'(1);
          st_r    <= ST_MUL;
        end
        ST_MUL: begin
          acc_r <= product;
          st_r  <= ST_ADD;
        end
        ST_ADD: begin
          if (count_r == LAST_INDEX) begin
            st_r <= ST_IDLE;
          end else begin
            count_r <= count_r + idx_t'(1);
            st_r    <= ST_MUL;
          end
        end
        default: begin
          st_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Word pushed into the chain tail.
  always_comb begin
    ctl.busy = (st_r != ST_IDLE);
    ctl.push = (st_r == ST_LOAD) || (st_r == ST_ADD);
    ctl.word = (st_r == ST_LOAD) ? acc_r : acc_r + WORD_BITS'(count_r);
  end

  `CHK_NEXT(a_last_word_ends, clk, rst_n, (st_r == ST_ADD) && (count_r == LAST_INDEX), !ctl.busy, "reseed did not end after the last word")
  `CHK_SAME(a_count_range, clk, rst_n, ctl.busy, count_r <= LAST_INDEX, "reseed word count out of range")
  `CHK_NEXT(a_start_loads, clk, rst_n, start && !ctl.busy, ctl.push && (ctl.word == $past(seed)), "seed not pushed first")

endmodule

// ===== sv/mt19937_generator.sv =====
// MT19937 generator top level: a chain of 624 word cells, the reseed sequencer
// and the output register. Depends on mtg_pkg, mtg_cell, mtg_seeder and
// assert_macros.svh.
//
// A draw transfer (in_tuser = 0) produces one tempered 32-bit word, and draws
// are accepted one per clock as long as no reseed is running and the output
// register is empty or being taken; the result appears in the cycle after the
// transfer. The state lives in a chain of 624 word cells that advances by one
// on every draw, so the current word, its successor and the word 397 places on
// sit at fixed cells. A reseed transfer (in_tuser = 1, seed in in_tdata) gives
// no result and holds in_tready low until the reseed has ended: the sequencer
// pushes the seed and then each further word through its multiplier and adder
// into the chain. Issue a reseed before the first draw.
`include "assert_macros.svh"

module mt19937_generator (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [31:0]            in_tdata,   // [31:0] seed_value
  input  logic [0:0]             in_tuser,   // [0] mode
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [31:0]            out_tdata   // [31:0] random_word
);
  import mtg_pkg::*;

  word_t     cell_word [STATE_WORDS];
  word_t     tail_in;
  word_t     twist_word;
  seed_ctl_t seed_ctl;
  logic      in_fire;
  logic      draw_fire;
  logic      reseed_fire;
  logic      shift_en;
  logic      out_valid_r;
  word_t     out_data_r;

  // Input handshake and item decode.
  assign in_tready   = !seed_ctl.busy && (!out_valid_r || out_tready);
  assign in_fire     = in_tvalid && in_tready;
  assign draw_fire   = in_fire && !in_tuser[0];
  assign reseed_fire = in_fire && in_tuser[0];

  // Twist from the fixed taps of the chain.
  assign twist_word = twist(cell_word[0], cell_word[1], cell_word[TWIST_OFFSET]);

  // The chain advances on a draw or on a word from the reseed sequencer.
  assign shift_en = draw_fire || seed_ctl.push;
  assign tail_in  = draw_fire ? twist_word : seed_ctl.word;

  mtg_seeder u_seeder (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (reseed_fire),
    .seed      (in_tdata),
    .tail_word (cell_word[STATE_WORDS-1]),
    .ctl       (seed_ctl)
  );

  // Row of word cells; each takes its upper neighbor, the last takes the tail input.
  for (genvar i = 0; i < STATE_WORDS; i++) begin : g_cell
    word_t nb_word;
    if (i == STATE_WORDS - 1) begin : g_tail
      assign nb_word = tail_in;
    end else begin : g_body
      assign nb_word = cell_word[i+1];
    end
    mtg_cell u_cell (
      .clk      (clk),
      .shift_en (shift_en),
      .shift_in (nb_word),
      .word     (cell_word[i])
    );
  end

  // Output register for the tempered word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (draw_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (draw_fire) begin
      out_data_r <= temper(twist_word);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `CHK_ALWAYS(a_no_shift_clash, clk, rst_n, !(draw_fire && seed_ctl.push), "draw and reseed push collide")
  `CHK_NEXT(a_draw_result, clk, rst_n, draw_fire, out_tvalid && (out_tdata == temper($past(twist_word))), "draw result missing")
  `CHK_NEXT(a_tail_twisted, clk, rst_n, draw_fire, cell_word[STATE_WORDS-1] == $past(twist_word), "twisted word not stored at the tail")

endmodule
